// ===== rtl/g4fb_pkg.sv =====
// ----------------------------------------------------------------------------
// g4fb_pkg: shared types and constants for the grey framebuffer fill unit
// Sequencer state codes, request kinds, pixel masks and grey level words.
// ----------------------------------------------------------------------------
package g4fb_pkg;

  localparam int WORD_BITS  = 32;
  localparam int PIX_PER_WD = 8;

  // request kinds carried on s_tuser
  localparam logic FUNC_FILL = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SETUP = 7'b0000100,
    ST_WORD  = 7'b0001000,
    ST_MERGE = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // pixels from offset k to the end of a word, pixel 0 in the top nibble
  function automatic logic [WORD_BITS-1:0] tail_mask(input logic [3:0] k);
    logic [WORD_BITS-1:0] m;
    case (k)
      4'd0:    m = 32'hffffffff;
      4'd1:    m = 32'h0fffffff;
      4'd2:    m = 32'h00ffffff;
      4'd3:    m = 32'h000fffff;
      4'd4:    m = 32'h0000ffff;
      4'd5:    m = 32'h00000fff;
      4'd6:    m = 32'h000000ff;
      4'd7:    m = 32'h0000000f;
      default: m = 32'h00000000;
    endcase
    return m;
  endfunction

  function automatic logic [WORD_BITS-1:0] grey_word(input logic [1:0] lvl);
    logic [WORD_BITS-1:0] g;
    case (lvl)
      2'd0:    g = 32'h00000000;
      2'd1:    g = 32'h55555555;
      2'd2:    g = 32'haaaaaaaa;
      default: g = 32'hffffffff;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/grey4_framebuffer_rect_fill_unit.sv =====
// ----------------------------------------------------------------------------
// grey4_framebuffer_rect_fill_unit: 4 bpp framebuffer with rectangle fill
// Holds the framebuffer in one memory and paints or reads it under a small
// sequencer that walks rows and words one at a time.
// ----------------------------------------------------------------------------
// The block owns a PIXEL_COLS x PIXEL_ROWS framebuffer at 4 bits per
// pixel, eight pixels per 32-bit word with the leftmost pixel in bits 31..28,
// ceil(PIXEL_COLS/8) words per row. After reset a clearing pass writes zero
// to every word, one word per cycle; s_tready stays low meanwhile. A request
// with s_tuser = 0 fills a rectangle with grey 0x0, 0x5, 0xA or 0xF; with
// s_tuser = 1 it returns one word (zero when word_index is past the end).
// Every request gives exactly one response. A read passes the setup, read
// and done states (setup and done alone when word_index is past the end);
// a fill passes setup, then for each painted row one word state per whole
// word and a word and a merge state per partial edge word (read, then masked
// write back), since the single memory port moves one word per cycle, then
// done. An empty or off-screen fill goes from setup straight to done. Parts
// of the rectangle past the right or bottom edge are not painted, and the
// response flags them in clipped. A finished response waits in the output
// register while the next request is accepted; a response that is still
// waiting there holds the next one in the done state until m_tready.
// ----------------------------------------------------------------------------
module grey4_framebuffer_rect_fill_unit #(
  parameter int PIXEL_COLS = 160,
  parameter int PIXEL_ROWS = 160
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // rect_x[7:0], rect_y[15:8], rect_width[23:16], rect_height[31:24],
  // grey_level[33:32], word_index[45:34], zero pad [47:46]
  input  logic [47:0] s_tdata,
  // func[0]: 0 fill rectangle, 1 read one word
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[31:0], clipped[32], zero pad [39:33]
  output logic [39:0] m_tdata
);
  import g4fb_pkg::*;

  localparam int WPR      = (PIXEL_COLS + PIX_PER_WD - 1) / PIX_PER_WD;
  localparam int FB_WORDS = WPR * PIXEL_ROWS;
  localparam int AW       = (FB_WORDS > 1) ? $clog2(FB_WORDS) : 1;
  localparam logic [10:0] SW_L     = 11'(PIXEL_COLS);
  localparam logic [10:0] SH_L     = 11'(PIXEL_ROWS);
  localparam logic [AW-1:0] WPR_A  = AW'(WPR);
  localparam logic [AW-1:0] LAST_A = AW'(FB_WORDS - 1);

  // request fields
  logic [7:0]  in_x, in_y, in_w, in_h;
  logic [1:0]  in_lvl;
  logic [11:0] in_widx;

  assign in_x    = s_tdata[7:0];
  assign in_y    = s_tdata[15:8];
  assign in_w    = s_tdata[23:16];
  assign in_h    = s_tdata[31:24];
  assign in_lvl  = s_tdata[33:32];
  assign in_widx = s_tdata[45:34];

  state_t state;

  // latched request
  logic        req_func;
  logic [7:0]  req_x, req_y, req_w, req_h;
  logic [1:0]  req_lvl;
  logic [11:0] req_widx;

  // fill walk
  logic [8:0]            row;
  logic [8:0]            end_y;
  logic [5:0]            wcol;
  logic [5:0]            first_w;
  logic [5:0]            last_w;
  logic [3:0]            last_hi;
  logic [AW-1:0]         row_base;
  logic [WORD_BITS-1:0]  colour;
  logic [AW-1:0]         clr_addr;

  // response register
  logic [WORD_BITS-1:0]  res_data;
  logic                  res_clip;
  logic                  out_load;

  // framebuffer memory
  logic [WORD_BITS-1:0]  fb_mem [FB_WORDS];
  logic [WORD_BITS-1:0]  rd_data;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [WORD_BITS-1:0]  mem_wdata;

  // setup arithmetic
  logic [8:0]  x1, y1, ex, ey, ex_m1;
  logic        cut;
  logic        widx_ok;

  always_comb begin
    x1      = {1'b0, req_x} + {1'b0, req_w};
    y1      = {1'b0, req_y} + {1'b0, req_h};
    ex      = ({2'b00, x1} > SW_L) ? SW_L[8:0] : x1;
    ey      = ({2'b00, y1} > SH_L) ? SH_L[8:0] : y1;
    cut     = ({2'b00, x1} > SW_L) || ({2'b00, y1} > SH_L);
    ex_m1   = ex - 9'd1;
    widx_ok = {20'd0, req_widx} < 32'(FB_WORDS);
  end

  // pixel mask of the current word
  logic [3:0]           lo, hi;
  logic [WORD_BITS-1:0] mask;
  logic [AW-1:0]        word_addr;
  logic                 row_end;

  always_comb begin
    lo        = (wcol == first_w) ? {1'b0, req_x[2:0]} : 4'd0;
    hi        = (wcol == last_w) ? last_hi : 4'd8;
    mask      = tail_mask(lo) & ~tail_mask(hi);
    word_addr = row_base + AW'(wcol);
    row_end   = (wcol == last_w);
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = word_addr;
    mem_wdata = colour;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      ST_SETUP: begin
        mem_re   = (req_func == FUNC_READ) && widx_ok;
        mem_addr = AW'(req_widx);
      end
      ST_WORD: begin
        // fully covered word: write directly; partial edge word: read first
        mem_we = (mask == '1);
        mem_re = (mask != '1);
      end
      ST_MERGE: begin
        mem_we    = 1'b1;
        mem_wdata = (rd_data & ~mask) | (colour & mask);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fb_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= fb_mem[mem_addr];
    end
  end

  assign s_tready = (state == ST_IDLE);

  // load the output register once it is free or being emptied
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_A) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            req_func <= s_tuser;
            req_x    <= in_x;
            req_y    <= in_y;
            req_w    <= in_w;
            req_h    <= in_h;
            req_lvl  <= in_lvl;
            req_widx <= in_widx;
            state    <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          res_data <= '0;
          if (req_func == FUNC_READ) begin
            res_clip <= 1'b0;
            state    <= widx_ok ? ST_READ : ST_DONE;
          end else begin
            res_clip <= cut;
            colour   <= grey_word(req_lvl);
            row      <= {1'b0, req_y};
            end_y    <= ey;
            row_base <= AW'(32'(req_y) * WPR);
            first_w  <= {1'b0, req_x[7:3]};
            wcol     <= {1'b0, req_x[7:3]};
            last_w   <= ex_m1[8:3];
            last_hi  <= {1'b0, ex_m1[2:0]} + 4'd1;
            // skip empty or off-screen rectangles
            if (({1'b0, req_x} < ex) && ({1'b0, req_y} < ey)) begin
              state <= ST_WORD;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_WORD, ST_MERGE: begin
          if (state == ST_WORD && mask != '1) begin
            state <= ST_MERGE;
          end else if (row_end) begin
            // advance to the next row of the span
            wcol     <= first_w;
            row      <= row + 9'd1;
            row_base <= row_base + WPR_A;
            state    <= (row + 9'd1 == end_y) ? ST_DONE : ST_WORD;
          end else begin
            wcol  <= wcol + 6'd1;
            state <= ST_WORD;
          end
        end
        ST_READ: begin
          res_data <= rd_data;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            m_tdata <= {7'd0, res_clip, res_data};
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/tb_grey4_framebuffer_rect_fill_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grey4_framebuffer_rect_fill_unit: self-checking bench for the fill unit
// Streams fill and read requests into the block, keeps a shadow framebuffer
// that is painted in request order, and compares every response word and
// clip flag with the shadow's answer. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_grey4_framebuffer_rect_fill_unit;
  import g4fb_pkg::*;

  localparam int SCREEN_W      = 160;
  localparam int SCREEN_H      = 160;
  localparam int WORDS_PER_ROW = (SCREEN_W + 7) / 8;
  localparam int FB_WORDS      = WORDS_PER_ROW * SCREEN_H;
  localparam int RANDOM_COUNT  = 500;
  localparam int CYCLE_LIMIT   = 10000000;
  localparam int GAP_PERCENT   = 15;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_PRINTED   = 40;

  // one request as it travels on the slave side
  typedef struct {
    logic        func;
    logic [7:0]  rect_x;
    logic [7:0]  rect_y;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [1:0]  grey_level;
    logic [11:0] word_index;
    bit          drain;       // hold this request until every response is back
  } fb_request_t;

  typedef struct {
    logic [31:0] read_data;
    logic        clipped;
  } fb_response_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = FUNC_FILL;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  fb_request_t  pending_requests[$];
  fb_response_t awaited_responses[$];
  fb_request_t  request_on_bus;
  logic [31:0]  shadow_fb [FB_WORDS];

  int unsigned request_total     = 0;
  int unsigned requests_accepted = 0;
  int unsigned responses_seen    = 0;
  int unsigned mismatch_count    = 0;
  int unsigned cycle_count       = 0;

  grey4_framebuffer_rect_fill_unit #(
    .PIXEL_COLS(SCREEN_W),
    .PIXEL_ROWS(SCREEN_H)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #6 clk = ~clk;

  // Pixels from column offset k to the end of the word; pixel 0 sits in
  // bits 31..28, so each step right drops one nibble off the top.
  function automatic logic [31:0] pixels_from(int k);
    if (k >= 8) begin
      return 32'h0;
    end
    return 32'hffffffff >> (4 * k);
  endfunction

  // Paint or read the shadow framebuffer; return the response it implies.
  function automatic fb_response_t apply_request(fb_request_t r);
    fb_response_t res;
    int           x_end;
    int           y_end;
    int           ex;
    int           ey;
    int           base;
    int           lo;
    int           hi;
    int           idx;
    logic [31:0]  mask;
    logic [31:0]  grey;
    res.read_data = 32'h0;
    res.clipped   = 1'b0;
    if (r.func == FUNC_READ) begin
      if (r.word_index < FB_WORDS) begin
        res.read_data = shadow_fb[r.word_index];
      end
      return res;
    end
    x_end = r.rect_x + r.rect_width;
    y_end = r.rect_y + r.rect_height;
    ex    = (x_end > SCREEN_W) ? SCREEN_W : x_end;
    ey    = (y_end > SCREEN_H) ? SCREEN_H : y_end;
    res.clipped = (x_end > SCREEN_W) || (y_end > SCREEN_H);
    grey  = {8{r.grey_level, r.grey_level}};
    // Start past the right edge or an empty span: paint nothing.
    if (r.rect_x < ex) begin
      for (int y = r.rect_y; y < ey; y++) begin
        for (int w = r.rect_x / 8; w <= (ex - 1) / 8; w++) begin
          base = w * 8;
          lo   = (r.rect_x > base) ? r.rect_x - base : 0;
          hi   = (ex < base + 8) ? ex - base : 8;
          mask = pixels_from(lo) & ~pixels_from(hi);
          idx  = y * WORDS_PER_ROW + w;
          shadow_fb[idx] = (shadow_fb[idx] & ~mask) | (grey & mask);
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch on response %0d: %s got %h expected %h",
               $realtime, responses_seen, what, got, want);
    end
  endtask

  task automatic queue_fill(int x, int y, int w, int h, int lvl, bit drain);
    fb_request_t r;
    r.func        = FUNC_FILL;
    r.rect_x      = 8'(x);
    r.rect_y      = 8'(y);
    r.rect_width  = 8'(w);
    r.rect_height = 8'(h);
    r.grey_level  = 2'(lvl);
    r.word_index  = 12'($urandom_range(0, 4095));
    r.drain       = drain;
    pending_requests.push_back(r);
  endtask

  task automatic queue_read(int idx, bit drain);
    fb_request_t r;
    r.func        = FUNC_READ;
    r.rect_x      = 8'($urandom_range(0, 255));
    r.rect_y      = 8'($urandom_range(0, 255));
    r.rect_width  = 8'($urandom_range(0, 255));
    r.rect_height = 8'($urandom_range(0, 255));
    r.grey_level  = 2'($urandom_range(0, 3));
    r.word_index  = 12'(idx);
    r.drain       = drain;
    pending_requests.push_back(r);
  endtask

  // Idle the sender at random, except over a calm stretch of requests.
  function automatic bit sender_gap();
    if (requests_accepted >= 200 && requests_accepted < 300) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < GAP_PERCENT;
  endfunction

  // Request driver: predict on acceptance, then load the next request or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_responses.push_back(apply_request(request_on_bus));
        requests_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() != 0 && !sender_gap() &&
            !(pending_requests[0].drain && awaited_responses.size() != 0)) begin
          request_on_bus = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= request_on_bus.func;
          s_tdata  <= {2'b00, request_on_bus.word_index, request_on_bus.grey_level,
                       request_on_bus.rect_height, request_on_bus.rect_width,
                       request_on_bus.rect_y, request_on_bus.rect_x};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: check against the oldest awaited response, stall at random.
  always @(posedge clk) begin
    fb_response_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_responses.size() == 0) begin
          report_mismatch("response with none outstanding", m_tdata[31:0], 32'h0);
        end else begin
          want = awaited_responses.pop_front();
          if (m_tdata[31:0] !== want.read_data) begin
            report_mismatch("read_data", m_tdata[31:0], want.read_data);
          end
          if (m_tdata[32] !== want.clipped) begin
            report_mismatch("clipped", {31'b0, m_tdata[32]}, {31'b0, want.clipped});
          end
        end
        responses_seen++;
      end
      m_tready <= (responses_seen >= 150 && responses_seen < 250) ||
                  ($urandom_range(0, 99) >= GAP_PERCENT);
    end
  end

  // Watchdog: abandon a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int r;
    int s;
    int last_x;
    int last_y;
    int idx;
    for (int i = 0; i < FB_WORDS; i++) begin
      shadow_fb[i] = 32'h0;
    end

    // Directed part: cleared memory, out-of-range reads, full screen, edge
    // words, single word, right and bottom clipping, start off screen, empty
    // rectangles and the last pixel of the screen.
    queue_read(0, 1'b0);
    queue_read(FB_WORDS - 1, 1'b0);
    queue_read(FB_WORDS, 1'b0);
    queue_read(4095, 1'b0);
    queue_fill(0, 0, 160, 160, 3, 1'b0);
    queue_read(1605, 1'b1);
    queue_fill(3, 5, 10, 2, 1, 1'b0);
    queue_read(100, 1'b0);
    queue_read(101, 1'b0);
    queue_fill(17, 0, 3, 1, 2, 1'b0);
    queue_read(2, 1'b0);
    queue_fill(150, 10, 20, 3, 0, 1'b0);
    queue_read(219, 1'b0);
    queue_fill(0, 155, 8, 10, 2, 1'b0);
    queue_read(3180, 1'b0);
    queue_fill(200, 0, 10, 10, 1, 1'b0);
    queue_fill(255, 255, 255, 255, 3, 1'b0);
    queue_fill(5, 5, 0, 5, 2, 1'b0);
    queue_fill(5, 5, 5, 0, 2, 1'b0);
    queue_fill(170, 3, 0, 0, 1, 1'b0);
    queue_fill(159, 159, 1, 1, 1, 1'b0);
    queue_read(FB_WORDS - 1, 1'b0);
    queue_fill(0, 0, 8, 1, 0, 1'b0);
    queue_read(0, 1'b0);

    // Random part: mostly small fills with reads aimed at the last one, a
    // share of edge fills, a few full-range and a few near-full-screen ones.
    last_x = 0;
    last_y = 0;
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        s = $urandom_range(0, 99);
        if (s < 60) begin
          idx = ((last_y % SCREEN_H + $urandom_range(0, 7)) % SCREEN_H) * WORDS_PER_ROW +
                ((last_x % SCREEN_W) / 8 + $urandom_range(0, 2)) % WORDS_PER_ROW;
        end else if (s < 90) begin
          idx = $urandom_range(0, FB_WORDS - 1);
        end else begin
          idx = $urandom_range(0, 4095);
        end
        queue_read(idx, i == 120 || i == 380);
      end else begin
        s = $urandom_range(0, 99);
        if (s < 75) begin
          last_x = $urandom_range(0, 159);
          last_y = $urandom_range(0, 159);
          queue_fill(last_x, last_y, $urandom_range(0, 24), $urandom_range(0, 12),
                     $urandom_range(0, 3), i == 120 || i == 380);
        end else if (s < 90) begin
          last_x = $urandom_range(130, 159);
          last_y = $urandom_range(140, 159);
          queue_fill(last_x, last_y, $urandom_range(0, 60), $urandom_range(0, 40),
                     $urandom_range(0, 3), i == 120 || i == 380);
        end else if (s < 97) begin
          last_x = $urandom_range(0, 255);
          last_y = $urandom_range(0, 255);
          queue_fill(last_x, last_y, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 3), i == 120 || i == 380);
        end else begin
          last_x = $urandom_range(0, 15);
          last_y = $urandom_range(0, 15);
          queue_fill(last_x, last_y, $urandom_range(120, 160), $urandom_range(100, 160),
                     $urandom_range(0, 3), i == 120 || i == 380);
        end
      end
    end
    request_total = pending_requests.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Settle on the falling edge so the driver and monitor have finished.
    while (requests_accepted < request_total || awaited_responses.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
